/* rtl/core/xet_pkg.sv */
// ----------------------------------------------------------------------------
// xet_pkg: shared types and constants of the character tokeniser
// Token kinds, scan modes, result records and the chunk length limit.
// ----------------------------------------------------------------------------
`default_nettype none

package xet_pkg;

  // Longest chunk before a forced chunk end, and the offset limit it gives.
  localparam longint unsigned MaxChunkBytes = 64'd65535;
  localparam logic [16:0] ChunkLimit =
      (MaxChunkBytes > 64'd65535) ? 17'd65535 : 17'(MaxChunkBytes);

  // Depth of the queue between the classifier and the output side.
  localparam int unsigned DefaultQueueDepth = 4;

  // Special characters.
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChBsl  = 8'h5C;
  localparam logic [7:0] ChNul  = 8'h00;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_LT      = 3'd1,
    KIND_GT      = 3'd2,
    KIND_AMP     = 3'd3,
    KIND_QUOT    = 3'd4,
    KIND_NEWLINE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    MODE_TOKEN = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_CR    = 2'd2,
    MODE_ESC   = 2'd3
  } mode_e;

  // One span result.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        partial;
  } span_t;

  // All results caused by one byte: one or two spans.
  typedef struct packed {
    logic           two;
    span_t [1:0]    res;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/xet_front.sv */
// ----------------------------------------------------------------------------
// xet_front: byte classifier of the character tokeniser
// Takes one byte per cycle while the queue is not full, tracks the open span
// and pushes the spans that each byte closes into the queue as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module xet_front
  import xet_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       chunk_end_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output entry_t          q_entry_o
);

  mode_e       mode_q, mode_d;
  mode_e       resume_q, resume_d;
  kind_e       okind_q, okind_d;
  logic [15:0] ostart_q, ostart_d;
  logic [15:0] offset_q, offset_d;

  logic        accept;
  logic [1:0]  n;
  logic        done;
  logic [16:0] nxt;
  span_t [1:0] res;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Scan state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TOKEN;
      resume_q <= MODE_TOKEN;
      okind_q  <= KIND_DATA;
      ostart_q <= '0;
      offset_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      resume_q <= resume_d;
      okind_q  <= okind_d;
      ostart_q <= ostart_d;
      offset_q <= offset_d;
    end
  end

  // Classification of one byte and the spans that it closes.
  always_comb begin
    mode_d   = mode_q;
    resume_d = resume_q;
    okind_d  = okind_q;
    ostart_d = ostart_q;
    offset_d = offset_q;
    n        = 2'd0;
    done     = 1'b0;
    res      = '0;
    nxt      = {1'b0, offset_q} + 17'd1;

    if (text_byte_i == ChNul) begin
      // A NUL cuts the open span and restarts offsets; the mode is kept.
      if (ostart_q < offset_q) begin
        res[n[0]] = '{kind: okind_q, span_start: ostart_q, span_end: offset_q,
                      partial: 1'b1};
        n = n + 2'd1;
      end
      ostart_d = '0;
      offset_d = '0;
    end else begin
      if (mode_d == MODE_ESC) begin
        mode_d = (resume_q == MODE_DATA) ? MODE_DATA : MODE_TOKEN;
      end

      if (mode_d == MODE_CR) begin
        if (text_byte_i == ChLf) begin
          // The LF completes a CR LF pair.
          res[n[0]] = '{kind: KIND_NEWLINE, span_start: ostart_d,
                        span_end: nxt[15:0], partial: 1'b0};
          n = n + 2'd1;
          ostart_d = nxt[15:0];
          mode_d   = MODE_TOKEN;
          done     = 1'b1;
        end else begin
          // A lone CR is a newline of its own.
          if (ostart_d < offset_q) begin
            res[n[0]] = '{kind: KIND_NEWLINE, span_start: ostart_d,
                          span_end: offset_q, partial: 1'b0};
            n = n + 2'd1;
          end
          ostart_d = offset_q;
          mode_d   = MODE_TOKEN;
        end
      end else if (mode_d != MODE_DATA) begin
        mode_d = MODE_TOKEN;
      end

      if (!done) begin
        if (text_byte_i == ChLt || text_byte_i == ChGt ||
            text_byte_i == ChAmp || text_byte_i == ChQuot) begin
          if (ostart_d < offset_q) begin
            res[n[0]] = '{kind: okind_d, span_start: ostart_d,
                          span_end: offset_q, partial: 1'b0};
            n = n + 2'd1;
          end
          case (text_byte_i)
            ChLt:    okind_d = KIND_LT;
            ChGt:    okind_d = KIND_GT;
            ChAmp:   okind_d = KIND_AMP;
            default: okind_d = KIND_QUOT;
          endcase
          ostart_d = offset_q;
          mode_d   = MODE_TOKEN;
        end else if (text_byte_i == ChCr) begin
          if (ostart_d < offset_q) begin
            res[n[0]] = '{kind: okind_d, span_start: ostart_d,
                          span_end: offset_q, partial: 1'b0};
            n = n + 2'd1;
          end
          okind_d  = KIND_NEWLINE;
          ostart_d = offset_q;
          mode_d   = MODE_CR;
        end else if (text_byte_i == ChLf) begin
          if (ostart_d < offset_q) begin
            res[n[0]] = '{kind: okind_d, span_start: ostart_d,
                          span_end: offset_q, partial: 1'b0};
            n = n + 2'd1;
          end
          res[n[0]] = '{kind: KIND_NEWLINE, span_start: offset_q,
                        span_end: nxt[15:0], partial: 1'b0};
          n = n + 2'd1;
          ostart_d = nxt[15:0];
          mode_d   = MODE_TOKEN;
        end else if (text_byte_i == ChBsl) begin
          // A backslash joins the open span, or opens a data span.
          if (ostart_d >= offset_q) begin
            okind_d  = KIND_DATA;
            ostart_d = offset_q;
            mode_d   = MODE_DATA;
          end
          resume_d = mode_d;
          mode_d   = MODE_ESC;
        end else if (mode_d == MODE_TOKEN) begin
          if (ostart_d < offset_q) begin
            res[n[0]] = '{kind: okind_d, span_start: ostart_d,
                          span_end: offset_q, partial: 1'b0};
            n = n + 2'd1;
          end
          okind_d  = KIND_DATA;
          ostart_d = offset_q;
          mode_d   = MODE_DATA;
        end
      end

      // Chunk end, given or forced by the length limit.
      if (chunk_end_i || nxt >= ChunkLimit) begin
        if ({1'b0, ostart_d} < nxt) begin
          res[n[0]] = '{kind: okind_d, span_start: ostart_d,
                        span_end: nxt[15:0], partial: 1'b1};
          n = n + 2'd1;
        end
        offset_d = '0;
        ostart_d = '0;
      end else begin
        offset_d = nxt[15:0];
      end
    end
  end

  assign q_push_o       = accept && (n != 2'd0);
  assign q_entry_o.two  = n[1];
  assign q_entry_o.res  = res;

endmodule

`default_nettype wire

/* rtl/core/xet_fifo.sv */
// ----------------------------------------------------------------------------
// xet_fifo: result queue of the character tokeniser
// Short first-in first-out queue of result entries between the classifier
// and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module xet_fifo
  import xet_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultQueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output entry_t      head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  entry_t          store_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = store_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // The classifier never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("result queue overflow");

  // The output side never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("result queue underflow");

  // The fill count rises by one on a push without a pop.
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("result queue count mismatch");

endmodule

`default_nettype wire

/* rtl/core/xet_back.sv */
// ----------------------------------------------------------------------------
// xet_back: output side of the character tokeniser
// Unpacks queue entries into single span results and holds each one in an
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module xet_back
  import xet_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_empty_i,
  input  wire entry_t q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output span_t       out_span_o,
  output logic        out_last_o
);

  logic  valid_q, valid_d;
  logic  sel_q, sel_d;
  logic  last_q;
  span_t span_q;
  logic  load;

  // Load a result when the output register is free or being emptied.
  assign load    = (!valid_q || out_ready_i) && !q_empty_i;
  assign q_pop_o = load && (sel_q || !q_head_i.two);

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !q_pop_o;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      span_q <= q_head_i.res[sel_q];
      last_q <= q_pop_o;
    end
  end

  assign out_valid_o = valid_q;
  assign out_span_o  = span_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* rtl/core/xml_escape_char_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// xml_escape_char_tokenizer_core: character tokeniser for escaped text
// Splits a text byte stream into token spans with chunk-relative offsets.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one text byte per transaction, tlast marking the
//   final byte of a chunk. The master stream carries one span per
//   transaction: offsets in tdata, kind and partial flag in tuser, and tlast
//   on the final span caused by a given input byte. Bytes that close no span
//   give no output transaction.
//   One byte is accepted per cycle while the queue is not full. A byte's
//   spans pass through the queue and then the output register; a byte giving
//   two spans fills the output register with each span in turn. The
//   classifier and the output register are parted by a queue of QUEUE_DEPTH
//   entries, so input stalls only when that queue is full.
//   When the receiver holds tready low the current span stays in the output
//   register and further entries gather in the queue; once it fills, tready
//   on the input side drops.
//   Reset clears the scan state to the start of a token at offset zero and
//   empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_escape_char_tokenizer_core
  import xet_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefaultQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // chunk_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] span_start, [31:16] span_end
  output logic [3:0]       m_axis_tuser,   // [2:0] token_kind, [3] is_partial
  output logic             m_axis_tlast    // last_of_run
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_in, q_head;
  span_t  out_span;

  // Classifier.
  xet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .text_byte_i (s_axis_tdata),
    .chunk_end_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  // Result queue.
  xet_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Output side.
  xet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_span_o  (out_span),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the span onto the master stream.
  assign m_axis_tdata = {out_span.span_end, out_span.span_start};
  assign m_axis_tuser = {out_span.partial, out_span.kind};

endmodule

`default_nettype wire
